/* src/aesd_pkg.sv */
package aesd_pkg;

   localparam int NumRounds = 10;
   localparam int RegIndexWidth = 1;

   typedef enum logic [RegIndexWidth-1:0] {
      REG_KEY_HIGH = 1'b0,
      REG_KEY_LOW  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic             valid;
      logic             func;
      logic [127:0]     chain;
   } side_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] p;
      logic [7:0] x;
      p = 8'h00;
      x = a;
      for (int n = 0; n < 4; n++) begin
         if (b[n]) p = p ^ x;
         x = xtime(x);
      end
      gmul = p;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // byte i of a 128-bit word, byte 0 in the top bits
   function automatic logic [7:0] byte_of(input logic [127:0] w, input int i);
      byte_of = w[127-8*i -: 8];
   endfunction

endpackage

/* src/aesd_key_cell.sv */
module aesd_key_cell (
   input  logic         clock,
   input  logic [127:0] prev_key,
   input  logic [7:0]   rcon,
   output logic [127:0] next_key_ff
);
   import aesd_pkg::*;

   logic [127:0] next_key_in;
   logic [31:0]  t;
   logic [31:0]  w0, w1, w2, w3;

   always_comb begin
      t = {SBOX[prev_key[23:16]] ^ rcon, SBOX[prev_key[15:8]],
           SBOX[prev_key[7:0]], SBOX[prev_key[31:24]]};
      w0 = prev_key[127:96] ^ t;
      w1 = prev_key[95:64] ^ w0;
      w2 = prev_key[63:32] ^ w1;
      w3 = prev_key[31:0] ^ w2;
      next_key_in = {w0, w1, w2, w3};
   end

   always_ff @(posedge clock) begin
      next_key_ff <= next_key_in;
   end

endmodule

/* src/aesd_round_cell.sv */
module aesd_round_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                mix_en,
   input  logic [127:0]        state_i,
   input  logic [127:0]        round_key,
   input  aesd_pkg::side_type  side_i,
   output logic [127:0]        state_ff,
   output aesd_pkg::side_type  side_ff
);
   import aesd_pkg::*;

   logic [127:0] state_in;
   logic [127:0] sub;
   logic [127:0] ark;
   logic [7:0]   a0, a1, a2, a3;

   always_comb begin
      // inverse shift rows and inverse sub bytes; byte index r + 4c
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sub[127-8*(r+4*c) -: 8] = INV_SBOX[byte_of(state_i, r + 4*((c - r) & 3))];
         end
      end
      ark = sub ^ round_key;
      state_in = ark;
      if (mix_en) begin
         for (int c = 0; c < 4; c++) begin
            a0 = byte_of(ark, 4*c);
            a1 = byte_of(ark, 4*c+1);
            a2 = byte_of(ark, 4*c+2);
            a3 = byte_of(ark, 4*c+3);
            state_in[127-32*c -: 32] = {
               gmul(a0,4'd14)^gmul(a1,4'd11)^gmul(a2,4'd13)^gmul(a3,4'd9),
               gmul(a0,4'd9)^gmul(a1,4'd14)^gmul(a2,4'd11)^gmul(a3,4'd13),
               gmul(a0,4'd13)^gmul(a1,4'd9)^gmul(a2,4'd14)^gmul(a3,4'd11),
               gmul(a0,4'd11)^gmul(a1,4'd13)^gmul(a2,4'd9)^gmul(a3,4'd14)};
         end
      end else begin
         a0 = 8'h00;
         a1 = 8'h00;
         a2 = 8'h00;
         a3 = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      side_ff.func <= side_i.func;
      side_ff.chain <= side_i.chain;
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff.valid <= side_i.valid;
      end
   end

endmodule

/* src/aes128_block_decrypt.sv */
// AES-128 block decryptor with optional CBC chaining. A transaction is taken
// on any cycle where start is high and busy is low; busy is always low, so a
// new block may enter every cycle. The datapath is a row of ten round cells,
// one register each, plus an input register for the initial key add: each
// result appears on rsp_valid exactly 11 cycles after its start and must be
// captured in that cycle, since the receiver cannot stall the row. Round keys
// are expanded by a row of ten key cells after a key write; allow 10 idle
// cycles after the last csr_ write before issuing start.
module aes128_block_decrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [63:0] req_cipher_high,
   input  logic [63:0] req_cipher_low,
   input  logic [63:0] req_chain_high,
   input  logic [63:0] req_chain_low,
   output logic        rsp_valid,
   output logic [63:0] rsp_plain_high,
   output logic [63:0] rsp_plain_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  aesd_pkg::reg_index_type csr_index,
   input  logic [63:0] csr_data
);
   import aesd_pkg::*;

   logic [63:0]  key_high_ff, key_low_ff;
   logic [127:0] rkey [NumRounds+1];
   logic [7:0]   rcon [NumRounds];
   logic [127:0] st   [NumRounds+1];
   side_type     sd   [NumRounds+1];
   side_type     side_in;
   logic [127:0] st_in;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   // hold the key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_KEY_HIGH: key_high_ff <= csr_data;
            REG_KEY_LOW:  key_low_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // round constants, advancing by xtime
   always_comb begin
      rcon[0] = 8'h01;
      for (int i = 1; i < NumRounds; i++) rcon[i] = xtime(rcon[i-1]);
   end

   assign rkey[0] = {key_high_ff, key_low_ff};

   for (genvar g = 0; g < NumRounds; g++) begin : g_key
      aesd_key_cell u_key (
         .clock       (clock),
         .prev_key    (rkey[g]),
         .rcon        (rcon[g]),
         .next_key_ff (rkey[g+1])
      );
   end

   // input stage: initial add of the last round key
   assign st_in = {req_cipher_high, req_cipher_low} ^ rkey[NumRounds];
   always_comb begin
      side_in.valid = start & ~busy;
      side_in.func = req_func;
      side_in.chain = {req_chain_high, req_chain_low};
   end

   always_ff @(posedge clock) begin
      st[0] <= st_in;
      sd[0].func <= side_in.func;
      sd[0].chain <= side_in.chain;
      if (reset) begin
         sd[0].valid <= 1'b0;
      end else begin
         sd[0].valid <= side_in.valid;
      end
   end

   // cell g applies round NumRounds-1-g; the final cell skips the column mix
   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      aesd_round_cell u_round (
         .clock     (clock),
         .reset     (reset),
         .mix_en    (g != NumRounds - 1),
         .state_i   (st[g]),
         .round_key (rkey[NumRounds-1-g]),
         .side_i    (sd[g]),
         .state_ff  (st[g+1]),
         .side_ff   (sd[g+1])
      );
   end

   // fold the chaining value in only when func asks for it
   always_comb begin
      rsp_valid = sd[NumRounds].valid;
      {rsp_plain_high, rsp_plain_low} = st[NumRounds] ^
         (sd[NumRounds].func ? sd[NumRounds].chain : 128'd0);
   end

   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##11 rsp_valid) else $error("result lost");
   a_no_spur: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, 11)) else $error("spurious result");

endmodule
